/* hdl/ffa_pkg.sv */
// Shared types and constants for the first-fit allocator.
// Holds the stream field widths, operation codes and the control/status
// structs between the controller and the datapath. No dependencies.
package ffa_pkg;

	// operation codes carried on s_tuser
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// fixed field widths of the stream words
	localparam int REQ_W      = 9;
	localparam int ADDR_W     = 8;
	localparam int USED_W     = 9;
	localparam int POOL_W     = 9;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;

	// controller -> datapath commands
	typedef struct packed {
		logic load;       // capture the input word
		logic scan_init;  // set up the scan pointer and run length
		logic scan;       // issue one map read, evaluate the previous one
		logic mark;       // write one unit of a granted block
		logic res_ok;     // flag a successful free
		logic clr_init;   // restart the clearing sweep, zero the used count
		logic clr_step;   // clear one map entry
		logic out_load;   // move the result into the output register
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic op_free;
		logic early_fail;
		logic hit;
		logic alloc_end;
		logic free_fail;
		logic free_done;
		logic mark_last;
		logic clr_last;
		logic out_free;
	} sts_t;

endpackage

/* hdl/ffa_ctrl.sv */
// Sequencer of the first-fit allocator: clearing sweep, request check,
// scans, block marking and result hand-off. Uses ffa_pkg.
module ffa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  ffa_pkg::sts_t sts,
	output ffa_pkg::cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_CHECK = 7'b0000100,
		ST_ALLOC = 7'b0001000,
		ST_MARK  = 7'b0010000,
		ST_FREE  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// a pool write takes priority, so refuse a request word in that cycle
	assign s_tready = (state_q == ST_IDLE) && !cfg_wr;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		if (cfg_wr) begin
			cmd.clr_init = 1'b1;
			state_d      = ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					cmd.clr_step = 1'b1;
					if (sts.clr_last) state_d = ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd.load = 1'b1;
						state_d  = ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (sts.early_fail) begin
						state_d = ST_DONE;
					end else begin
						cmd.scan_init = 1'b1;
						state_d       = sts.op_free ? ST_FREE : ST_ALLOC;
					end
				end
				ST_ALLOC: begin
					cmd.scan = 1'b1;
					if (sts.hit) state_d = ST_MARK;
					else if (sts.alloc_end) state_d = ST_DONE;
				end
				ST_MARK: begin
					cmd.mark = 1'b1;
					if (sts.mark_last) state_d = ST_DONE;
				end
				ST_FREE: begin
					cmd.scan = 1'b1;
					if (sts.free_fail) begin
						state_d = ST_DONE;
					end else if (sts.free_done) begin
						cmd.res_ok = 1'b1;
						state_d    = ST_DONE;
					end
				end
				ST_DONE: begin
					if (sts.out_free) begin
						cmd.out_load = 1'b1;
						state_d      = ST_IDLE;
					end
				end
				default: state_d = ST_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

endmodule

/* hdl/ffa_dp.sv */
// Datapath of the first-fit allocator: unit map memory, scan pointer,
// run counter, used count, pool register and output register. Uses ffa_pkg.
module ffa_dp #(
	parameter int MAX_UNITS = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr,
	input  logic [ffa_pkg::POOL_W-1:0]         cfg_data,
	input  logic [ffa_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                               s_tuser,
	input  ffa_pkg::cmd_t                      cmd,
	output ffa_pkg::sts_t                      sts,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ffa_pkg::OUT_DATA_W-1:0]     m_tdata
);

	localparam int AW = $clog2(MAX_UNITS);
	localparam int CW = $clog2(MAX_UNITS + 1);

	// map entry: [1] unit used, [0] block starts here
	logic [1:0]                   mem_q [MAX_UNITS];
	logic [1:0]                   rdat_s1;
	logic [CW-1:0]                pool_q, pool_d;
	logic [AW-1:0]                clr_q;
	logic [CW-1:0]                cnt_q;
	logic                         op_free_q;
	logic [ffa_pkg::REQ_W-1:0]    req_q;
	logic [ffa_pkg::ADDR_W-1:0]   fad_q;
	logic [CW-1:0]                idx_q;
	logic [AW-1:0]                idx_s1;
	logic                         vld_s1;
	logic [CW-1:0]                run_q;
	logic [AW-1:0]                mark_q, mark_end_q, grant_q;
	logic                         ok_q;
	logic                         out_valid_q, out_ok_q;
	logic [ffa_pkg::ADDR_W-1:0]   out_grant_q;
	logic [ffa_pkg::USED_W-1:0]   out_used_q;

	logic                         used, start, head, last, hit, free_clr;
	logic [AW-1:0]                start_addr;
	logic                         we;
	logic [AW-1:0]                waddr;
	logic [1:0]                   wdata;

	// clamp the pool size into 1..MAX_UNITS
	always_comb begin
		if (cfg_data == '0) pool_d = CW'(1);
		else if (32'(cfg_data) > 32'(MAX_UNITS)) pool_d = CW'(MAX_UNITS);
		else pool_d = CW'(cfg_data);
	end

	assign used       = rdat_s1[1];
	assign start      = rdat_s1[0];
	assign head       = (32'(idx_s1) == 32'(fad_q));
	assign last       = (32'(idx_s1) + 32'd1 == 32'(pool_q));
	assign hit        = !op_free_q && vld_s1 && !used && (32'(run_q) + 32'd1 == 32'(req_q));
	assign start_addr = AW'(32'(idx_s1) + 32'd1 - 32'(req_q));
	// release the head of the block, then its continuation units
	assign free_clr   = op_free_q && vld_s1 && (head ? (used && start) : (used && !start));

	always_comb begin
		sts.op_free    = op_free_q;
		sts.early_fail = op_free_q ? (32'(fad_q) >= 32'(pool_q))
		                           : (req_q == '0 || 32'(req_q) > 32'(pool_q));
		sts.hit        = hit;
		sts.alloc_end  = !op_free_q && vld_s1 && !hit && last;
		sts.free_fail  = op_free_q && vld_s1 && head && !(used && start);
		sts.free_done  = op_free_q && vld_s1 &&
		                 ((!head && !(used && !start)) || (free_clr && last));
		sts.mark_last  = (mark_q == mark_end_q);
		sts.clr_last   = (clr_q == AW'(MAX_UNITS - 1));
		sts.out_free   = !out_valid_q || m_tready;
	end

	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = 2'b00;
		if (cmd.clr_step) begin
			we = 1'b1;
		end else if (cmd.mark) begin
			we    = 1'b1;
			waddr = mark_q;
			wdata = {1'b1, mark_q == grant_q};
		end else if (cmd.scan && free_clr) begin
			we    = 1'b1;
			waddr = idx_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdat_s1 <= mem_q[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q      <= CW'(MAX_UNITS);
			clr_q       <= '0;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) pool_q <= pool_d;
			if (cmd.clr_init) begin
				clr_q <= '0;
				cnt_q <= '0;
			end else begin
				if (cmd.clr_step) clr_q <= clr_q + 1'b1;
				if (cmd.scan && hit) cnt_q <= CW'(32'(cnt_q) + 32'(req_q));
				else if (cmd.scan && free_clr) cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.scan_init) vld_s1 <= 1'b0;
			else if (cmd.scan) vld_s1 <= (32'(idx_q) < 32'(pool_q));
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_free_q <= (s_tuser == ffa_pkg::OP_FREE);
			req_q     <= s_tdata[ffa_pkg::REQ_W-1:0];
			fad_q     <= s_tdata[ffa_pkg::REQ_W +: ffa_pkg::ADDR_W];
			ok_q      <= 1'b0;
			grant_q   <= '0;
		end
		if (cmd.scan_init) begin
			idx_q <= op_free_q ? CW'(fad_q) : '0;
			run_q <= '0;
		end else if (cmd.scan) begin
			idx_q  <= idx_q + 1'b1;
			idx_s1 <= idx_q[AW-1:0];
			if (vld_s1) run_q <= used ? '0 : run_q + 1'b1;
		end
		if (cmd.scan && hit) begin
			ok_q       <= 1'b1;
			grant_q    <= start_addr;
			mark_q     <= start_addr;
			mark_end_q <= idx_s1;
		end
		if (cmd.mark) mark_q <= mark_q + 1'b1;
		if (cmd.res_ok) ok_q <= 1'b1;
		if (cmd.out_load) begin
			out_ok_q    <= ok_q;
			out_grant_q <= ffa_pkg::ADDR_W'(grant_q);
			out_used_q  <= ffa_pkg::USED_W'(cnt_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {
		(ffa_pkg::OUT_DATA_W - 1 - ffa_pkg::ADDR_W - ffa_pkg::USED_W)'(0),
		out_used_q, out_grant_q, out_ok_q
	};

	a_cnt_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(pool_q))
		else $error("used count exceeds pool size");

	a_wr_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(we && !cmd.clr_step) |-> (32'(waddr) < 32'(pool_q)))
		else $error("map write outside the pool");

	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ok_q) |-> (out_grant_q == '0))
		else $error("failed result carries an address");

endmodule

/* hdl/first_fit_allocator.sv */
// Top level of the first-fit allocator: controller and datapath.
// Depends on ffa_pkg, ffa_ctrl and ffa_dp.
//
// Usage:
//   s_* carries requests. s_tuser is the operation (0 allocate, 1 free);
//   s_tdata holds request_units in [8:0] and free_address in [16:9].
//   m_* returns one word per request: success [0], granted_address [8:1],
//   used_total [17:9].
//   cfg_* writes pool_units; a write clamps the value into 1..MAX_UNITS
//   and clears the whole map. cfg_ready is always high.
// Sequence:
//   One request at a time. Allocate: a setup step, a first-fit scan from
//   unit 0 (one map entry per cycle through the memory read port), marking
//   of the granted block unit by unit, then posting of the result. Free: a
//   setup step, a release scan of the block from free_address, then
//   posting. Rejected requests post straight after the check.
//   A new request is taken while the previous result still waits on m_*;
//   if m_tready stays low the block holds its next result in place.
// Reset and configuration:
//   After reset, and after every configuration write, the map memory is
//   swept clear entry by entry; s_tready stays low during the sweep.
module first_fit_allocator #(
	parameter int MAX_UNITS = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request words
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ffa_pkg::IN_DATA_W-1:0]      s_tdata,  // request_units, free_address
	input  logic                               s_tuser,  // operation
	// result words
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ffa_pkg::OUT_DATA_W-1:0]     m_tdata,  // success, granted_address, used_total
	// pool size register
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ffa_pkg::POOL_W-1:0]         cfg_data
);

	ffa_pkg::cmd_t cmd;
	ffa_pkg::sts_t sts;
	logic          cfg_wr;

	// the register is always writable; a write restarts the clearing sweep
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	ffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffa_dp #(
		.MAX_UNITS (MAX_UNITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
